// ===== rtl/core/run_sort_and_kway_merge_defines.svh =====
// Assertion macros for the run sort and merge RTL.
// Needs clk and rst in scope where a macro is used.
`ifndef RUN_SORT_AND_KWAY_MERGE_DEFINES_SVH
`define RUN_SORT_AND_KWAY_MERGE_DEFINES_SVH

// Same-cycle implication, held off during reset
`define RSKM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset
`define RSKM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/rskm_pkg.sv =====
// Shared constants, codes and controller/datapath structs for the run sorter.
// No dependencies.
package rskm_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int MAX_RUNS_DEF = 8;

  localparam int VALUE_W      = 32;
  localparam int RUN_COUNT_W  = 4;
  localparam int RUN_LENGTH_W = 11;
  localparam int TOTAL_W      = RUN_COUNT_W + RUN_LENGTH_W;
  localparam int STATUS_W     = 2;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 11;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RUN_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_LENGTH = 1'b1;

  localparam logic [RUN_COUNT_W-1:0]  RUN_COUNT_RST  = 4'd1;
  localparam logic [RUN_LENGTH_W-1:0] RUN_LENGTH_RST = 11'd1024;

  // Request actions
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TAKE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED = 2'd0,
    ST_VALUE  = 2'd1,
    ST_ERROR  = 2'd2
  } status_t;

  typedef struct packed {
    logic load_wr;
    logic run_first;
    logic run_next;
    logic rd_key;
    logic key_cap;
    logic rd_prev;
    logic shift_wr;
    logic key_wr;
    logic merge_begin;
    logic scan_rd;
    logic scan_cmp;
    logic take_commit;
    logic empty;
    logic res_ok;
    logic res_err;
  } cmd_t;

  typedef struct packed {
    logic geom_ok;
    logic is_take;
    logic merging;
    logic load_room;
    logic load_final;
    logic r_done;
    logic i_done;
    logic j_zero;
    logic prev_gt;
    logic head_done;
    logic found;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/rskm_in_if.sv =====
// Request channel: action and value with a valid/ready handshake.
// Depends on rskm_pkg.
interface rskm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 action;
  logic signed [rskm_pkg::VALUE_W-1:0]  value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

// ===== rtl/core/rskm_out_if.sv =====
// Result channel: merged value, last flag and status with valid/ready.
// Depends on rskm_pkg.
interface rskm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rskm_pkg::VALUE_W-1:0]  result_value;
  logic                                 last;
  logic [rskm_pkg::STATUS_W-1:0]        status;

  modport source (output valid, result_value, last, status, input ready);
  modport sink   (input valid, result_value, last, status, output ready);
endinterface

// ===== rtl/core/rskm_ctrl.sv =====
// Controller FSM: decodes requests, sequences the insertion sort and merge scan.
// Depends on rskm_pkg; drives the datapath through cmd_t, watches sts_t.
module rskm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rskm_pkg::sts_t sts,
  output rskm_pkg::cmd_t cmd
);
  import rskm_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_SORT_RUN = 11'b000_0000_0010,
    S_SORT_I   = 11'b000_0000_0100,
    S_SORT_KEY = 11'b000_0000_1000,
    S_SORT_CHK = 11'b000_0001_0000,
    S_SORT_CMP = 11'b000_0010_0000,
    S_SCAN     = 11'b000_0100_0000,
    S_SCAN_CMP = 11'b000_1000_0000,
    S_EMIT_OK  = 11'b001_0000_0000,
    S_EMIT_ERR = 11'b010_0000_0000,
    S_EMIT_VAL = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (!sts.geom_ok) begin
            state_next = S_EMIT_ERR;
          end else if (!sts.is_take) begin
            if (sts.merging || !sts.load_room) begin
              state_next = S_EMIT_ERR;
            end else begin
              cmd.load_wr = 1'b1;
              if (sts.load_final) begin
                cmd.run_first = 1'b1;
                state_next    = S_SORT_RUN;
              end else begin
                state_next = S_EMIT_OK;
              end
            end
          end else if (!sts.merging) begin
            state_next = S_EMIT_ERR;
          end else begin
            cmd.run_first = 1'b1;
            state_next    = S_SCAN;
          end
        end
      end
      S_SORT_RUN: begin
        if (sts.r_done) begin
          cmd.merge_begin = 1'b1;
          state_next      = S_EMIT_OK;
        end else begin
          state_next = S_SORT_I;
        end
      end
      S_SORT_I: begin
        if (sts.i_done) begin
          cmd.run_next = 1'b1;
          state_next   = S_SORT_RUN;
        end else begin
          cmd.rd_key = 1'b1;
          state_next = S_SORT_KEY;
        end
      end
      S_SORT_KEY: begin
        cmd.key_cap = 1'b1;
        state_next  = S_SORT_CHK;
      end
      S_SORT_CHK: begin
        if (sts.j_zero) begin
          cmd.key_wr = 1'b1;
          state_next = S_SORT_I;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = S_SORT_CMP;
        end
      end
      S_SORT_CMP: begin
        if (sts.prev_gt) begin
          cmd.shift_wr = 1'b1;
          state_next   = S_SORT_CHK;
        end else begin
          cmd.key_wr = 1'b1;
          state_next = S_SORT_I;
        end
      end
      S_SCAN: begin
        if (sts.r_done) begin
          if (sts.found) begin
            state_next = S_EMIT_VAL;
          end else begin
            cmd.empty  = 1'b1;
            state_next = S_EMIT_ERR;
          end
        end else if (sts.head_done) begin
          cmd.run_next = 1'b1;
        end else begin
          cmd.scan_rd = 1'b1;
          state_next  = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        cmd.scan_cmp = 1'b1;
        state_next   = S_SCAN;
      end
      S_EMIT_OK: begin
        if (sts.out_free) begin
          cmd.res_ok = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EMIT_ERR: begin
        if (sts.out_free) begin
          cmd.res_err = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_EMIT_VAL: begin
        if (sts.out_free) begin
          cmd.take_commit = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/rskm_datapath.sv =====
// Datapath: value store, counters, run heads, sort/scan indexes and result register.
// Depends on rskm_pkg and run_sort_and_kway_merge_defines.svh.
`include "run_sort_and_kway_merge_defines.svh"

module rskm_datapath #(
  parameter int CAPACITY = rskm_pkg::CAPACITY_DEF,
  parameter int MAX_RUNS = rskm_pkg::MAX_RUNS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rskm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rskm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                action,
  input  logic signed [rskm_pkg::VALUE_W-1:0] value,
  input  rskm_pkg::cmd_t                      cmd,
  output rskm_pkg::sts_t                      sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rskm_pkg::VALUE_W-1:0] out_value,
  output logic                                out_last,
  output logic [rskm_pkg::STATUS_W-1:0]       out_status
);
  import rskm_pkg::*;

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int SW  = ((CW > RUN_LENGTH_W) ? CW : RUN_LENGTH_W) + 1;
  localparam int RCW = $clog2(MAX_RUNS + 1);
  localparam int RIW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;

  logic [RUN_COUNT_W-1:0]      run_count;
  logic [RUN_LENGTH_W-1:0]     run_length;
  logic [TOTAL_W-1:0]          total;
  logic                        merging;
  logic [CW-1:0]               loaded;
  logic [CW-1:0]               emitted;
  logic [RUN_LENGTH_W-1:0]     heads [MAX_RUNS];
  logic [RCW-1:0]              r;
  logic [RIW-1:0]              r_idx;
  logic [CW-1:0]               base;
  logic [CW-1:0]               base_adv;
  logic [RUN_LENGTH_W-1:0]     i;
  logic [RUN_LENGTH_W-1:0]     j;
  logic signed [VALUE_W-1:0]   key;
  logic signed [VALUE_W-1:0]   best;
  logic                        found;
  logic                        better;
  logic [RIW-1:0]              pick;
  logic                        take_final;
  logic                        do_empty;

  logic signed [VALUE_W-1:0]   mem [CAPACITY];
  logic signed [VALUE_W-1:0]   rd_data;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic signed [VALUE_W-1:0]   wr_data;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [SW-1:0]               sum_i;
  logic [SW-1:0]               sum_j;
  logic [SW-1:0]               sum_jm1;
  logic [SW-1:0]               sum_head;
  logic [SW-1:0]               sum_len;

  // Geometry
  assign total = TOTAL_W'(run_count) * TOTAL_W'(run_length);
  assign r_idx = r[RIW-1:0];

  // Address arithmetic off the current run base
  assign sum_i    = SW'(base) + SW'(i);
  assign sum_j    = SW'(base) + SW'(j);
  assign sum_jm1  = sum_j - SW'(1);
  assign sum_head = SW'(base) + SW'(heads[r_idx]);
  assign sum_len  = SW'(base) + SW'(run_length);
  assign base_adv = sum_len[CW-1:0];

  assign take_final = (32'(emitted) + 32'd1) >= 32'(total);
  assign better     = !found || (rd_data < best);
  assign do_empty   = cfg_we || cmd.empty || (cmd.take_commit && take_final);

  // Status to the controller
  always_comb begin
    sts.geom_ok    = (run_count != '0) && (32'(run_count) <= 32'(MAX_RUNS)) &&
                     (run_length != '0) && (32'(total) <= 32'(CAPACITY));
    sts.is_take    = (action == ACT_TAKE);
    sts.merging    = merging;
    sts.load_room  = 32'(loaded) < 32'(total);
    sts.load_final = (32'(loaded) + 32'd1) == 32'(total);
    sts.r_done     = 32'(r) == 32'(run_count);
    sts.i_done     = i >= run_length;
    sts.j_zero     = (j == '0);
    sts.prev_gt    = rd_data > key;
    sts.head_done  = heads[r_idx] >= run_length;
    sts.found      = found;
    sts.out_free   = !out_valid || out_ready;
  end

  // Memory port selection
  always_comb begin
    wr_en   = cmd.load_wr || cmd.shift_wr || cmd.key_wr;
    wr_addr = cmd.load_wr ? loaded[AW-1:0] : sum_j[AW-1:0];
    if (cmd.load_wr) begin
      wr_data = value;
    end else if (cmd.shift_wr) begin
      wr_data = rd_data;
    end else begin
      wr_data = key;
    end
    rd_en = cmd.rd_key || cmd.rd_prev || cmd.scan_rd;
    if (cmd.rd_key) begin
      rd_addr = sum_i[AW-1:0];
    end else if (cmd.rd_prev) begin
      rd_addr = sum_jm1[AW-1:0];
    end else begin
      rd_addr = sum_head[AW-1:0];
    end
  end

  // Value store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Control state: configuration, counters, heads, indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      run_count  <= RUN_COUNT_RST;
      run_length <= RUN_LENGTH_RST;
      merging    <= 1'b0;
      loaded     <= '0;
      emitted    <= '0;
      r          <= '0;
      base       <= '0;
      i          <= RUN_LENGTH_W'(1);
      j          <= '0;
      found      <= 1'b0;
      out_valid  <= 1'b0;
      for (int k = 0; k < MAX_RUNS; k++) begin
        heads[k] <= '0;
      end
    end else begin
      // drop the result once taken
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_RUN_COUNT:  run_count  <= cfg_data[RUN_COUNT_W-1:0];
          REG_RUN_LENGTH: run_length <= cfg_data[RUN_LENGTH_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.load_wr) begin
        loaded <= loaded + CW'(1);
      end
      if (cmd.run_first) begin
        r     <= '0;
        base  <= '0;
        i     <= RUN_LENGTH_W'(1);
        found <= 1'b0;
      end
      // advance to the next run
      if (cmd.run_next || cmd.scan_cmp) begin
        r    <= r + RCW'(1);
        base <= base_adv;
        i    <= RUN_LENGTH_W'(1);
      end
      if (cmd.rd_key) begin
        j <= i;
      end
      if (cmd.key_wr) begin
        i <= i + RUN_LENGTH_W'(1);
      end
      if (cmd.shift_wr) begin
        j <= j - RUN_LENGTH_W'(1);
      end
      if (cmd.scan_cmp && better) begin
        found <= 1'b1;
      end
      if (cmd.merge_begin) begin
        merging <= 1'b1;
        emitted <= '0;
        for (int k = 0; k < MAX_RUNS; k++) begin
          heads[k] <= '0;
        end
      end
      if (cmd.take_commit) begin
        heads[pick] <= heads[pick] + RUN_LENGTH_W'(1);
        emitted     <= emitted + CW'(1);
      end
      if (cmd.take_commit || cmd.res_ok || cmd.res_err) begin
        out_valid <= 1'b1;
      end
      // empty the block
      if (do_empty) begin
        merging <= 1'b0;
        loaded  <= '0;
        emitted <= '0;
        for (int k = 0; k < MAX_RUNS; k++) begin
          heads[k] <= '0;
        end
      end
    end
  end

  // Payload: sort key, merge winner, result fields
  always_ff @(posedge clk) begin
    if (cmd.key_cap) begin
      key <= rd_data;
    end
    if (cmd.scan_cmp && better) begin
      best <= rd_data;
      pick <= r_idx;
    end
    if (cmd.take_commit) begin
      out_value  <= best;
      out_last   <= take_final;
      out_status <= ST_VALUE;
    end else if (cmd.res_ok) begin
      out_value  <= '0;
      out_last   <= 1'b0;
      out_status <= ST_LOADED;
    end else if (cmd.res_err) begin
      out_value  <= '0;
      out_last   <= 1'b0;
      out_status <= ST_ERROR;
    end
  end

  `RSKM_ASSERT_NOW(a_one_write, 1'b1, $onehot0({cmd.load_wr, cmd.shift_wr, cmd.key_wr}), "more than one store write")
  `RSKM_ASSERT_NOW(a_load_room, cmd.load_wr, sts.load_room, "load beyond total")
  `RSKM_ASSERT_NEXT(a_final_empties, cmd.take_commit && take_final, !merging && (loaded == '0), "final take did not empty the block")
  `RSKM_ASSERT_NOW(a_last_is_value, out_valid && out_last, out_status == ST_VALUE, "last on a non-value result")

endmodule

// ===== rtl/core/run_sort_and_kway_merge.sv =====
// Top level of the run sorter with k-way merge: controller plus datapath.
// Depends on rskm_pkg, rskm_in_if, rskm_out_if, rskm_ctrl, rskm_datapath.
//
// Usage: write run_count (index 0) and run_length (index 1) on the cfg port
// while idle; a write also empties the block. Send requests on item_in:
// action 0 loads value, action 1 takes the next merged value. Each request
// gets exactly one result on result_out with status 0 (load taken),
// 1 (value delivered, last set on the final one) or 2 (error).
// Flow: the load that completes the total starts an in-place insertion
// sort of every run on the store, one compare/shift step at a time
// (run_length squared over 2 steps per run in the worst case).
// A take scans every run head through the store read port.
// One request is worked at a time; a new request is accepted while the
// previous result still sits in the output register.
// Reset: synchronous rst restores run_count 1, run_length 1024 and an empty
// block; the store itself is not cleared. When result_out stalls, the
// finished result holds and the next result waits in the controller.
module run_sort_and_kway_merge #(
  parameter int CAPACITY = rskm_pkg::CAPACITY_DEF,
  parameter int MAX_RUNS = rskm_pkg::MAX_RUNS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rskm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rskm_pkg::CFG_DATA_W-1:0] cfg_data,
  rskm_in_if.sink                         item_in,
  rskm_out_if.source                      result_out
);
  import rskm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  rskm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_in.valid),
    .in_ready (item_in.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Store, counters and result register
  rskm_datapath #(
    .CAPACITY (CAPACITY),
    .MAX_RUNS (MAX_RUNS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .action     (item_in.action),
    .value      (item_in.value),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (result_out.valid),
    .out_ready  (result_out.ready),
    .out_value  (result_out.result_value),
    .out_last   (result_out.last),
    .out_status (result_out.status)
  );

endmodule
